// ===== design/msam_pkg.sv =====
// ----------------------------------------------------------------------------
// msam_pkg
// Shared codes, widths and constants of the multi-slot audio mixer.
// ----------------------------------------------------------------------------
package msam_pkg;

  localparam int OP_W    = 3;
  localparam int SAMP_W  = 16;
  localparam int GAIN_W  = 17;
  localparam int CNT_W   = 32;
  localparam int CFGI_W  = 3;
  localparam int PF_W    = 7;
  localparam int CH_W    = 4;
  localparam int N_W     = 11;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic signed [SAMP_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]        gain_t;

  localparam op_t OP_WRITE = 3'd0;
  localparam op_t OP_MIX   = 3'd1;
  localparam op_t OP_OPEN  = 3'd2;
  localparam op_t OP_CLOSE = 3'd3;
  localparam op_t OP_QUERY = 3'd4;

  localparam logic [CFGI_W-1:0] CFG_VOL0   = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_VOL3   = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_PERIOD = 3'd4;
  localparam logic [CFGI_W-1:0] CFG_CHAN   = 3'd5;

  localparam gain_t UNITY_GAIN = 17'h10000;
  localparam logic [PF_W-1:0] PERIOD_RST = 7'd32;
  localparam logic [CH_W-1:0] CHAN_RST   = 4'd2;

  localparam logic signed [18:0] SAMP_MAX = 19'sd32767;
  localparam logic signed [18:0] SAMP_MIN = -19'sd32768;

endpackage

// ===== design/multi_slot_audio_mixer_core.sv =====
// ----------------------------------------------------------------------------
// multi_slot_audio_mixer_core
// Per-slot ring FIFOs in one sample memory, Q16 gain mixing with clipping.
// ----------------------------------------------------------------------------
// Write, open, close and query: result word registered on accept.
// Mix: each active slot's contribution takes the memory read, multiply and
// accumulate states in turn, then each output word is issued in S_OUT, which
// waits while the output stalls. One item in flight at a time.
// Reset (rst_n low, synchronous) clears slots, pointers, counters and control
// state; output data and the sample memory are not, and need no clearing pass.
module multi_slot_audio_mixer_core #(
  parameter int SLOTS             = 4,
  parameter int MAX_PERIOD_FRAMES = 32,
  parameter int MAX_CHANNELS      = 2,
  parameter int RING_DEPTH        = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  msam_pkg::op_t            in_operation,
  input  logic [1:0]               in_slot_id,
  input  msam_pkg::sample_t        in_sample_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output msam_pkg::sample_t        out_mixed_sample,
  output logic                     out_last_of_period,
  output logic                     out_status,
  output logic [1:0]               out_granted_slot,
  output logic [31:0]              out_underrun_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [16:0]              cfg_data
);
  import msam_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(2 * RING_DEPTH);
  localparam int IW = $clog2(RING_DEPTH);
  localparam int AW = $clog2(SLOTS * RING_DEPTH);
  localparam int MIX_MAX = MAX_PERIOD_FRAMES * MAX_CHANNELS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  sample_t            mem [SLOTS*RING_DEPTH];
  sample_t            mem_q_r;
  logic [PW-1:0]      wp_r [SLOTS];
  logic [PW-1:0]      rp_r [SLOTS];
  logic [SLOTS-1:0]   act_r;
  logic [CNT_W-1:0]   urun_r [SLOTS];
  logic [N_W-1:0]     take_r [SLOTS];
  gain_t              vol_r [SLOTS];
  logic [PF_W-1:0]    pf_r;
  logic [CH_W-1:0]    ch_r;
  logic [2:0]         state_r;
  logic [SW-1:0]      s_r;
  logic [N_W-1:0]     j_r;
  logic [N_W-1:0]     n_r;
  logic signed [33:0] prod_r;
  sample_t            acc_r;
  logic               use_r;

  logic               out_free, accept;
  logic               out_load;
  logic               sid_ok;
  logic [SW-1:0]      sid;
  logic [PW:0]        fill_sid;
  logic               wr_ok;
  logic [N_W-1:0]     n_raw, n_cur;
  logic [SW-1:0]      first_act, next_act, free_slot;
  logic               has_next, has_free;
  logic [PW:0]        avail [SLOTS];
  logic [PW-1:0]      ridx_p;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic signed [17:0] gained;
  logic signed [18:0] sum;
  sample_t            clipped;
  gain_t              vol_sat;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(2 * RING_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [IW-1:0] ptr_idx(input logic [PW-1:0] p);
    ptr_idx = (p >= PW'(RING_DEPTH)) ? IW'(p - PW'(RING_DEPTH)) : IW'(p);
  endfunction

  function automatic logic [PW:0] ptr_fill(input logic [PW-1:0] w, input logic [PW-1:0] r);
    ptr_fill = (w >= r) ? {1'b0, w - r} : ({1'b0, w} + (PW+1)'(2 * RING_DEPTH)) - {1'b0, r};
  endfunction

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_load = (accept && ((in_operation == OP_WRITE) || (in_operation == OP_OPEN) ||
                                (in_operation == OP_CLOSE) || (in_operation == OP_QUERY))) ||
                    ((state_r == S_OUT) && out_free);

  assign sid_ok   = {1'b0, in_slot_id} < 3'(SLOTS);
  assign sid      = SW'(in_slot_id);
  assign fill_sid = ptr_fill(wp_r[sid], rp_r[sid]);
  assign wr_ok    = sid_ok && act_r[sid] && (fill_sid < (PW+1)'(RING_DEPTH));

  assign n_raw = N_W'(pf_r) * N_W'(ch_r);
  assign n_cur = (n_raw > N_W'(MIX_MAX)) ? N_W'(MIX_MAX) : n_raw;

  always_comb begin
    first_act = '0;
    next_act  = '0;
    has_next  = 1'b0;
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (act_r[i]) begin
        first_act = SW'(i);
      end
      if (act_r[i] && (SW'(i) > s_r)) begin
        next_act = SW'(i);
        has_next = 1'b1;
      end
      if (!act_r[i]) begin
        free_slot = SW'(i);
        has_free  = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      avail[i] = ptr_fill(wp_r[i], rp_r[i]);
    end
  end

  assign ridx_p  = rp_r[s_r];
  assign rd_addr = AW'(AW'(s_r) * AW'(RING_DEPTH) + AW'(ptr_idx(ridx_p)));
  assign wr_addr = AW'(AW'(sid) * AW'(RING_DEPTH) + AW'(ptr_idx(wp_r[sid])));

  assign gained  = prod_r[33:16];
  assign sum     = 19'(acc_r) + 19'(gained);
  assign clipped = (sum > SAMP_MAX) ? SAMP_MAX[15:0] :
                   (sum < SAMP_MIN) ? SAMP_MIN[15:0] : sum[15:0];
  assign vol_sat = (cfg_data > UNITY_GAIN) ? UNITY_GAIN : cfg_data;

  always_ff @(posedge clk) begin
    if (accept && (in_operation == OP_WRITE) && wr_ok) begin
      mem[wr_addr] <= in_sample_in;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= 34'(use_r ? mem_q_r : sample_t'(0)) * $signed({1'b0, vol_r[s_r]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      act_r     <= '0;
      pf_r      <= PERIOD_RST;
      ch_r      <= CHAN_RST;
      out_valid <= 1'b0;
      s_r       <= '0;
      j_r       <= '0;
      n_r       <= '0;
      acc_r     <= '0;
      use_r     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        wp_r[i]   <= '0;
        rp_r[i]   <= '0;
        urun_r[i] <= '0;
        take_r[i] <= '0;
        vol_r[i]  <= UNITY_GAIN;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_VOL3) begin
          if ({1'b0, cfg_index} < 4'(SLOTS)) begin
            vol_r[SW'(cfg_index - CFG_VOL0)] <= vol_sat;
          end
        end else if (cfg_index == CFG_PERIOD) begin
          if (cfg_data[5:0] == 6'd0) begin
            pf_r <= PF_W'(1);
          end else if (PF_W'(cfg_data[5:0]) > PF_W'(MAX_PERIOD_FRAMES)) begin
            pf_r <= PF_W'(MAX_PERIOD_FRAMES);
          end else begin
            pf_r <= PF_W'(cfg_data[5:0]);
          end
        end else if (cfg_index == CFG_CHAN) begin
          if (cfg_data[1:0] == 2'd0) begin
            ch_r <= CH_W'(1);
          end else if (CH_W'(cfg_data[1:0]) > CH_W'(MAX_CHANNELS)) begin
            ch_r <= CH_W'(MAX_CHANNELS);
          end else begin
            ch_r <= CH_W'(cfg_data[1:0]);
          end
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_mixed_sample   <= '0;
            out_last_of_period <= 1'b0;
            priority case (in_operation)
              OP_WRITE: begin
                out_status         <= !wr_ok;
                out_granted_slot   <= '0;
                out_underrun_count <= '0;
                if (wr_ok) begin
                  wp_r[sid] <= ptr_inc(wp_r[sid]);
                end
              end
              OP_MIX: begin
                if (act_r != '0) begin
                  n_r     <= n_cur;
                  j_r     <= '0;
                  acc_r   <= '0;
                  s_r     <= first_act;
                  state_r <= S_ADDR;
                  for (int i = 0; i < SLOTS; i++) begin
                    if (32'(avail[i]) < 32'(n_cur)) begin
                      take_r[i] <= N_W'(avail[i]);
                      if (act_r[i]) begin
                        urun_r[i] <= urun_r[i] + CNT_W'(1);
                      end
                    end else begin
                      take_r[i] <= n_cur;
                    end
                  end
                end
              end
              OP_OPEN: begin
                out_underrun_count <= '0;
                if (has_free) begin
                  act_r[free_slot]  <= 1'b1;
                  wp_r[free_slot]   <= '0;
                  rp_r[free_slot]   <= '0;
                  urun_r[free_slot] <= '0;
                  out_granted_slot  <= 2'(free_slot);
                  out_status        <= 1'b0;
                end else begin
                  out_granted_slot  <= '0;
                  out_status        <= 1'b1;
                end
              end
              OP_CLOSE: begin
                out_status         <= !sid_ok;
                out_granted_slot   <= '0;
                out_underrun_count <= '0;
                if (sid_ok) begin
                  act_r[sid] <= 1'b0;
                  wp_r[sid]  <= '0;
                  rp_r[sid]  <= '0;
                end
              end
              OP_QUERY: begin
                out_status         <= !sid_ok;
                out_granted_slot   <= '0;
                out_underrun_count <= sid_ok ? urun_r[sid] : '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADDR: begin
          use_r <= j_r < take_r[s_r];
          if (j_r < take_r[s_r]) begin
            rp_r[s_r] <= ptr_inc(rp_r[s_r]);
          end
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r <= clipped;
          if (has_next) begin
            s_r     <= next_act;
            state_r <= S_ADDR;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_mixed_sample   <= acc_r;
            out_last_of_period <= (j_r + N_W'(1)) == n_r;
            out_status         <= 1'b0;
            out_granted_slot   <= '0;
            out_underrun_count <= '0;
            acc_r              <= '0;
            s_r                <= first_act;
            j_r                <= j_r + N_W'(1);
            state_r            <= ((j_r + N_W'(1)) == n_r) ? S_IDLE : S_ADDR;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
